// ----- rtl/cqso_pkg.sv -----
// Package for the circular queue with search operations.
// Holds depth, widths, operation kinds and shared types; no dependencies.
package cqso_pkg;
   localparam int unsigned DEPTH      = 16;
   localparam int unsigned IDX_W      = $clog2(DEPTH);
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned TALLY_W    = 6;
   localparam int unsigned HEAD_RESET = 7;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [WORD_W-1:0] word_type;

   localparam logic [2:0] KIND_ENQ = 3'd0;
   localparam logic [2:0] KIND_DEQ = 3'd1;
   localparam logic [2:0] KIND_REM = 3'd2;
   localparam logic [2:0] KIND_EVN = 3'd3;
   localparam logic [2:0] KIND_DBL = 3'd4;

   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic zero_rem;
   } div_rsp_type;
endpackage

// ----- rtl/cqso_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module cqso_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/cqso_divider.sv -----
// Bit-serial unsigned remainder unit: one quotient bit per cycle.
// Depends on cqso_pkg.
module cqso_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  cqso_pkg::div_req_type req,
   output cqso_pkg::div_rsp_type rsp
);
   import cqso_pkg::*;

   logic [WORD_W:0]          rem_ff, rem_in;
   word_type                 quo_ff, quo_in;
   word_type                 dsr_ff, dsr_in;
   logic [$clog2(WORD_W):0]  cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [WORD_W:0]          shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[WORD_W-1:0], quo_ff[WORD_W-1]};
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dsr_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = shifted - {1'b0, dsr_ff};
         end else begin
            rem_in = shifted;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(WORD_W)+1)'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.zero_rem = (rem_ff == '0);
endmodule

// ----- rtl/circular_queue_with_search_ops_core.sv -----
// Circular queue of signed 32-bit words with search operations (top level).
// Depends on cqso_pkg, cqso_ram and cqso_divider.
//
// Usage: one request transaction on req_ (tdata = kind, operand) performs one
// operation: enqueue, dequeue, remove_item, remove_even or double_multiples.
// Each request yields one or more response transactions on rsp_; the final
// one carries tlast = 1 and the status (success, tally, now_empty, now_full).
// remove_even also emits one response per removed even word before status.
// The queue holds DEPTH-1 words; one slot always stays unused.
// Sequencing: enqueue passes FETCH and then offers the status; dequeue passes
// FETCH, WAIT and EVAL first. Walking kinds pass FETCH, WAIT and EVAL for each
// word visited, plus EMIT for each even word response; each rotation of
// remove_item passes ROT, WAIT and EVAL, and a miss first works out the
// rotation count in MOD by repeated subtraction. double_multiples also waits
// in DIV for each word on the bit-serial remainder unit (one quotient bit a
// cycle). One request is worked at a time; req_tready is low from acceptance
// until the status has been taken.
// Reset: the queue is empty, head at slot 7, tail at slot 6. Store contents
// are not cleared; only slots inside the queue are ever read.
// Stall: while rsp_tready is low the response is held and the walk pauses.
module circular_queue_with_search_ops_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [2:0] kind, [34:3] operand, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // [31:0] word, [32] has_word, [33] success,
                                   // [39:34] tally, [40] now_empty, [41] now_full
   output logic        rsp_tlast
);
   import cqso_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FETCH = 4'd1;  // issue read of current slot
   localparam logic [3:0] ST_WAIT  = 4'd2;  // read data settles
   localparam logic [3:0] ST_EVAL  = 4'd3;  // decide on fetched word
   localparam logic [3:0] ST_DIV   = 4'd4;  // remainder unit running
   localparam logic [3:0] ST_EMIT  = 4'd5;  // even word waiting on rsp
   localparam logic [3:0] ST_STAT  = 4'd6;  // status waiting on rsp
   localparam logic [3:0] ST_ROT   = 4'd7;  // rotation pass of remove_item
   localparam logic [3:0] ST_MOD   = 4'd8;  // rotation count on a miss

   localparam idx_type HEAD_RST = idx_type'(HEAD_RESET % DEPTH);
   localparam idx_type TAIL_RST = idx_type'((HEAD_RESET + DEPTH - 1) % DEPTH);

   logic [3:0]         st_ff, st_in;
   logic [2:0]         kind_ff, kind_in;
   word_type           opnd_ff, opnd_in;
   idx_type            head_ff, head_in, tail_ff, tail_in;
   idx_type            pos_ff, pos_in;     // walk offset / rotations left
   idx_type            n_ff, n_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic               ok_ff, ok_in;
   word_type           word_ff, word_in;
   logic               has_ff, has_in;
   logic               rot_ff, rot_in;     // rotation pass in progress

   logic     wr_en;
   idx_type  wr_addr, rd_addr;
   word_type wr_data, rd_data;

   div_req_type div_req;
   div_rsp_type div_rsp;

   idx_type tail_nx, tail_nx2, head_nx, count;
   word_type mag_rd, mag_op;

   cqso_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   cqso_divider u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   assign tail_nx  = tail_ff + 1'b1;
   assign tail_nx2 = tail_ff + 2'd2;
   assign head_nx  = head_ff + 1'b1;
   assign count    = tail_nx - head_ff;
   assign mag_rd   = rd_data[WORD_W-1] ? (~rd_data + 1'b1) : rd_data;
   assign mag_op   = opnd_ff[WORD_W-1] ? (~opnd_ff + 1'b1) : opnd_ff;

   always_comb begin
      st_in    = st_ff;
      kind_in  = kind_ff;
      opnd_in  = opnd_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      pos_in   = pos_ff;
      n_in     = n_ff;
      tally_in = tally_ff;
      ok_in    = ok_ff;
      word_in  = word_ff;
      has_in   = has_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_nx;
      wr_data  = opnd_ff;
      rd_addr  = head_ff + pos_ff;
      div_req.start    = 1'b0;
      div_req.dividend = mag_rd;
      div_req.divisor  = mag_op;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tdata[2:0];
               opnd_in  = req_tdata[34:3];
               pos_in   = '0;
               n_in     = count;
               tally_in = '0;
               ok_in    = 1'b0;
               word_in  = '0;
               has_in   = 1'b0;
               st_in    = ST_FETCH;
            end
         end
         ST_FETCH: begin
            st_in = ST_WAIT;
            case (kind_ff) inside
               KIND_ENQ: begin
                  if (tail_nx2 != head_ff) begin
                     wr_en   = 1'b1;
                     tail_in = tail_nx;
                     ok_in   = 1'b1;
                  end
                  st_in = ST_STAT;
               end
               KIND_DEQ: begin
                  if (n_ff == '0) begin
                     st_in = ST_STAT;
                  end
               end
               KIND_REM, KIND_EVN: begin
                  if (pos_ff == n_ff) begin
                     st_in = ST_STAT;
                  end
               end
               KIND_DBL: begin
                  if (pos_ff == n_ff || mag_op == '0) begin
                     st_in = ST_STAT;
                  end
               end
               default: st_in = ST_STAT;
            endcase
         end
         ST_WAIT: st_in = ST_EVAL;
         ST_EVAL: begin
            case (kind_ff)
               KIND_DEQ: begin
                  word_in = rd_data;
                  has_in  = 1'b1;
                  ok_in   = 1'b1;
                  head_in = head_nx;
                  st_in   = ST_STAT;
               end
               KIND_REM: begin
                  if (rd_data == opnd_ff) begin
                     ok_in = 1'b1;
                     st_in = ST_ROT;  // pos_ff rotations, then drop front
                  end else if (pos_ff + 1'b1 == n_ff) begin
                     // miss: reduce DEPTH-1 by n until below n
                     pos_in = idx_type'(DEPTH - 1);
                     st_in  = ST_MOD;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                     st_in  = ST_FETCH;
                  end
               end
               KIND_EVN: begin
                  head_in = head_nx;
                  pos_in  = pos_ff + 1'b1;
                  if (!rd_data[0]) begin
                     word_in  = rd_data;
                     tally_in = tally_ff + 1'b1;
                     st_in    = ST_EMIT;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = rd_data;
                     tail_in = tail_nx;
                     st_in   = ST_FETCH;
                     pos_in  = pos_ff + 1'b1;
                  end
               end
               KIND_DBL: begin
                  div_req.start = 1'b1;
                  opnd_in       = opnd_ff;
                  word_in       = rd_data;
                  st_in         = ST_DIV;
               end
               default: st_in = ST_STAT;
            endcase
            // remove_even reads at head, not head+pos
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.zero_rem) begin
                  wr_en    = 1'b1;
                  wr_addr  = head_ff + pos_ff;
                  wr_data  = {word_ff[WORD_W-2:0], 1'b0};
                  tally_in = tally_ff + 1'b1;
               end
               pos_in = pos_ff + 1'b1;
               st_in  = ST_FETCH;
            end
         end
         ST_MOD: begin
            // one subtraction a cycle; the remainder is the rotation count
            if (pos_ff >= n_ff) begin
               pos_in = pos_ff - n_ff;
            end else begin
               st_in = ST_ROT;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               st_in = ST_FETCH;
            end
         end
         ST_ROT: begin
            // one rotation costs a read then a write: it passes through WAIT and EVAL
            rd_addr = head_ff;
            if (pos_ff == '0) begin
               if (ok_ff) begin
                  head_in = head_nx;
               end
               st_in = ST_STAT;
            end else begin
               st_in = ST_WAIT;
               kind_in = kind_ff;
            end
         end
         ST_STAT: begin
            if (rsp_tready) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase

      // remove_even and rotations always read the front slot
      if (kind_ff == KIND_EVN) begin
         rd_addr = head_ff;
      end
      if (st_ff == ST_WAIT && rot_ff) begin
         rd_addr = head_ff;
      end
      if (st_ff == ST_EVAL && rot_ff) begin
         wr_en   = 1'b1;
         wr_data = rd_data;
         wr_addr = tail_nx;
         head_in = head_nx;
         tail_in = tail_nx;
         pos_in  = pos_ff - 1'b1;
         st_in   = ST_ROT;
         word_in = word_ff;
         ok_in   = ok_ff;
      end
   end

   // rotation pass flag: set on entering ST_ROT, held while rotating
   assign rot_in = (st_in == ST_ROT) || ((st_ff == ST_ROT || rot_ff) &&
                   (st_in == ST_WAIT || st_in == ST_EVAL));

   // remove_even walks n words with head moving; pos counts visited words
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         head_ff <= HEAD_RST;
         tail_ff <= TAIL_RST;
         rot_ff  <= 1'b0;
      end else begin
         st_ff   <= st_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         rot_ff  <= rot_in;
      end
      kind_ff  <= kind_in;
      opnd_ff  <= opnd_in;
      pos_ff   <= pos_in;
      n_ff     <= n_in;
      tally_ff <= tally_in;
      ok_ff    <= ok_in;
      word_ff  <= word_in;
      has_ff   <= has_in;
   end

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = (st_ff == ST_EMIT) || (st_ff == ST_STAT);
   assign rsp_tlast  = (st_ff == ST_STAT);
   always_comb begin
      rsp_tdata = '0;
      if (st_ff == ST_EMIT) begin
         rsp_tdata[31:0] = word_ff;
         rsp_tdata[32]   = 1'b1;
      end else begin
         rsp_tdata[31:0]  = has_ff ? word_ff : '0;
         rsp_tdata[32]    = has_ff;
         rsp_tdata[33]    = ok_ff;
         rsp_tdata[39:34] = (kind_ff == KIND_EVN || kind_ff == KIND_DBL) ?
                            tally_ff : '0;
         rsp_tdata[40]    = (tail_nx == head_ff);
         rsp_tdata[41]    = (tail_nx2 == head_ff);
      end
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_stat_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("rsp dropped");
   a_div_only_dbl: assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> (kind_ff == KIND_DBL)) else $error("divider misuse");
endmodule

// ----- sim/circular_queue_with_search_ops_core_test.sv -----
// Self-checking bench for the circular queue with search operations.
// Depends on cqso_pkg and the circular_queue_with_search_ops_core RTL.
module circular_queue_with_search_ops_core_test;
   import cqso_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic        rlast;
      logic        full;
      logic        empty;
      logic [5:0]  tally;
      logic        success;
      logic        has_word;
      logic [31:0] word;
   } outcome_type;

   // Shadow queue plus the list of outcomes still awaited
   class queue_scoreboard;
      logic [31:0] ring [DEPTH];
      int unsigned head, tail;
      outcome_type awaited [$];
      int errors;

      function new();
         head = HEAD_RESET % DEPTH;
         tail = (HEAD_RESET + DEPTH - 1) % DEPTH;
         errors = 0;
      endfunction

      function int unsigned step(int unsigned i);
         return (i + 1) % DEPTH;
      endfunction

      function bit is_empty();
         return step(tail) == head;
      endfunction

      function bit is_full();
         return step(step(tail)) == head;
      endfunction

      function int unsigned count();
         return (tail + 1 + DEPTH - head) % DEPTH;
      endfunction

      function void rotate();
         logic [31:0] v;
         v = ring[head];
         head = step(head);
         tail = step(tail);
         ring[tail] = v;
      endfunction

      function logic [31:0] mag(logic [31:0] v);
         return v[31] ? -v : v;
      endfunction

      function void note_request(logic [2:0] kind, logic [31:0] opnd);
         outcome_type st, ev;
         int unsigned n, pos, idx;
         logic [31:0] d, v;
         st = '0;
         n = count();
         case (kind)
            KIND_ENQ: begin
               if (!is_full()) begin
                  tail = step(tail);
                  ring[tail] = opnd;
                  st.success = 1;
               end
            end
            KIND_DEQ: begin
               if (!is_empty()) begin
                  st.word = ring[head];
                  head = step(head);
                  st.has_word = 1;
                  st.success = 1;
               end
            end
            KIND_REM: begin
               if (n != 0) begin
                  pos = n;
                  for (int i = 0; i < n; i++)
                     if (pos == n && ring[(head + i) % DEPTH] == opnd) pos = i;
                  if (pos < n) begin
                     for (int i = 0; i < pos; i++) rotate();
                     head = step(head);
                     st.success = 1;
                  end else begin
                     for (int i = 0; i < (DEPTH - 1) % n; i++) rotate();
                  end
               end
            end
            KIND_EVN: begin
               for (int i = 0; i < n; i++) begin
                  v = ring[head];
                  if (!v[0]) begin
                     head = step(head);
                     ev = '0;
                     ev.word = v;
                     ev.has_word = 1;
                     awaited.push_back(ev);
                     st.tally++;
                  end else begin
                     rotate();
                  end
               end
            end
            KIND_DBL: begin
               d = mag(opnd);
               if (d != 0)
                  for (int i = 0; i < n; i++) begin
                     idx = (head + i) % DEPTH;
                     if (mag(ring[idx]) % d == 0) begin
                        ring[idx] = ring[idx] << 1;
                        st.tally++;
                     end
                  end
            end
            default: ;
         endcase
         st.empty = is_empty();
         st.full = is_full();
         st.rlast = 1;
         awaited.push_back(st);
      endfunction

      function void check_response(outcome_type got);
         outcome_type exp;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         exp = awaited.pop_front();
         if (got !== exp) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp, got);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;

   queue_scoreboard board = new();
   int  idle_pct = 32;      // idling chance per side, in percent
   bit  hold_off = 0;       // receiver long stall in force
   int  quiet = 0;          // cycles with nothing accepted
   logic [31:0] live [$];   // words believed present, for search hits

   circular_queue_with_search_ops_core DUT (.*);

   always #10 clock = ~clock;

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_response({rsp_tlast, rsp_tdata[41:0]});
         quiet = ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) ? 0 : quiet + 1;
         if (quiet >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Receiver: random back-pressure, or a held stall
   always @(negedge clock)
      rsp_tready <= !reset && !hold_off && ($urandom_range(99) >= idle_pct);

   task automatic send(logic [2:0] kind, logic [31:0] opnd);
      // Idle at random with valid low, then offer the transaction
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'b0, opnd, kind};
      // Hold until accepted at a rising edge, then move on at the falling edge
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, opnd);
      if (kind == KIND_ENQ) live.push_back(opnd);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom;
         default: return $urandom_range(40) - 20;
      endcase
   endfunction

   initial begin
      logic [2:0] k;
      logic [31:0] w;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: empty-queue corner cases, fill past full, every kind
      send(KIND_DEQ, 0);
      send(KIND_REM, 5);
      send(KIND_EVN, 0);
      send(KIND_DBL, 3);
      for (int i = 0; i < 16; i++)
         send(KIND_ENQ, (i == 0) ? 32'h8000_0000 : (i == 1) ? 32'h7fff_ffff :
              (i == 2) ? 32'hffff_fffe : i * 3);
      send(KIND_DBL, 0);
      send(KIND_DBL, 32'h8000_0000);
      send(KIND_DBL, -3);
      send(KIND_REM, 9 * 2);
      send(KIND_REM, 32'h1234_5678);
      send(KIND_EVN, 0);
      send(3'd5, $urandom);
      send(3'd7, 32'hffff_ffff);

      // Back-pressure: stall the receiver while requests keep coming
      fork
         begin
            hold_off = 1;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 6; i++) send(KIND_ENQ, pick_word());
      join

      // Random: a mix of all kinds with enqueues the most common, searches mostly on present words
      for (int i = 0; i < 400; i++) begin
         if (i == 150) idle_pct = 0;
         if (i == 230) idle_pct = 32;
         case ($urandom_range(19)) inside
            0, 1, 2, 3, 4, 5, 6: k = KIND_ENQ;
            7, 8, 9: k = KIND_DEQ;
            10, 11, 12: k = KIND_REM;
            13, 14: k = KIND_EVN;
            15, 16, 17: k = KIND_DBL;
            18: k = 3'($urandom_range(7));
            default: k = 3'($urandom_range(7, 5));
         endcase
         if (k == KIND_REM && live.size() > 0 && $urandom_range(3) != 0)
            w = live[$urandom_range(live.size() - 1)];
         else if (k == KIND_DBL)
            w = ($urandom_range(7) == 0) ? pick_word() : $urandom_range(9) - 4;
         else
            w = pick_word();
         if (live.size() > 64) live.delete(0);
         send(k, w);
      end
      req_tvalid <= 0;

      while (board.awaited.size() != 0) @(negedge clock);
      repeat (600) @(negedge clock);
      if (board.errors == 0 && board.awaited.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/cqso_pkg.sv
rtl/cqso_ram.sv
rtl/cqso_divider.sv
rtl/circular_queue_with_search_ops_core.sv
sim/circular_queue_with_search_ops_core_test.sv
